### rtl/dssm_pkg.sv
// Package for the two-stacks-in-one-array block: sizes, codes and the
// control/status structs between the controller and the datapath. No dependencies.
package dssm_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  // operation and stack select codes
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_POP     = 1'b1;
  localparam logic STACK_LOW  = 1'b0;
  localparam logic STACK_HIGH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic take;     // input beat accepted this cycle
    logic capture;  // RAM read data valid, load it into the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_go;   // present item is a pop on a non-empty stack
  } dp_stat_t;

endpackage

### rtl/dssm_ram.sv
// Generic single-port RAM, one write or one read per cycle, registered read.
// No dependencies.
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/dssm_ctrl.sv
// Controller: idle / read / respond sequencer for the dual stack.
// Depends on dssm_pkg.
module dssm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dssm_pkg::dp_stat_t   stat,
  output dssm_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_RESP);
  assign cmd.take    = in_valid && in_ready;
  assign cmd.capture = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.pop_go ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/dssm_dp.sv
// Datapath: stack counters, address generation, shared word RAM, result register.
// Depends on dssm_pkg and dssm_ram.
module dssm_dp #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dssm_pkg::ctrl_cmd_t                 cmd,
  output dssm_pkg::dp_stat_t                  stat,
  input  logic                                in_op,
  input  logic                                in_which_stack,
  input  logic signed [dssm_pkg::DATA_W-1:0]  in_push_value,
  output logic signed [dssm_pkg::DATA_W-1:0]  out_pop_value,
  output logic [dssm_pkg::STATUS_W-1:0]       out_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [CW-1:0] low_cnt_r, low_cnt_nxt;
  logic [CW-1:0] high_cnt_r, high_cnt_nxt;
  logic [dssm_pkg::DATA_W-1:0]   value_r, value_nxt;
  logic [dssm_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [dssm_pkg::DATA_W-1:0]   ram_rdata;

  logic [CW-1:0] used;
  logic          full;
  logic          sel_empty;
  logic          push_ok;
  logic          pop_ok;
  logic [CW-1:0] addr_c;

  // both counts together never exceed DEPTH, so CW bits hold the sum
  assign used      = low_cnt_r + high_cnt_r;
  assign full      = (used == CW'(DEPTH));
  assign sel_empty = (in_which_stack == dssm_pkg::STACK_HIGH) ? (high_cnt_r == '0)
                                                              : (low_cnt_r == '0);
  assign push_ok   = (in_op == dssm_pkg::OP_PUSH) && !full;
  assign pop_ok    = (in_op == dssm_pkg::OP_POP) && !sel_empty;

  assign stat.pop_go = pop_ok;

  always_comb begin
    case ({in_which_stack, in_op})
      {dssm_pkg::STACK_LOW,  dssm_pkg::OP_PUSH}: addr_c = low_cnt_r;
      {dssm_pkg::STACK_LOW,  dssm_pkg::OP_POP }: addr_c = low_cnt_r - CW'(1);
      {dssm_pkg::STACK_HIGH, dssm_pkg::OP_PUSH}: addr_c = CW'(DEPTH - 1) - high_cnt_r;
      {dssm_pkg::STACK_HIGH, dssm_pkg::OP_POP }: addr_c = CW'(DEPTH) - high_cnt_r;
      default:                                   addr_c = '0;
    endcase
  end

  dssm_ram #(
    .WIDTH (dssm_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.take && push_ok),
    .re    (cmd.take && pop_ok),
    .addr  (addr_c[AW-1:0]),
    .wdata (in_push_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    value_nxt    = value_r;
    status_nxt   = status_r;
    if (cmd.take) begin
      value_nxt = '0;
      if (in_op == dssm_pkg::OP_PUSH) begin
        status_nxt = push_ok ? dssm_pkg::ST_OK : dssm_pkg::ST_OVERFLOW;
        if (push_ok) begin
          if (in_which_stack == dssm_pkg::STACK_HIGH) begin
            high_cnt_nxt = high_cnt_r + CW'(1);
          end else begin
            low_cnt_nxt = low_cnt_r + CW'(1);
          end
        end
      end else begin
        status_nxt = pop_ok ? dssm_pkg::ST_OK : dssm_pkg::ST_EMPTY;
        if (pop_ok) begin
          if (in_which_stack == dssm_pkg::STACK_HIGH) begin
            high_cnt_nxt = high_cnt_r - CW'(1);
          end else begin
            low_cnt_nxt = low_cnt_r - CW'(1);
          end
        end
      end
    end
    if (cmd.capture) begin
      value_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
    end else begin
      low_cnt_r  <= low_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign out_pop_value = value_r;
  assign out_status    = status_r;

endmodule

### rtl/dual_stack_shared_memory_top.sv
// Top level of the dual stack: two LIFO stacks in one shared word RAM.
// Depends on dssm_pkg, dssm_ctrl and dssm_dp (which holds dssm_ram).
//
// Two stacks share one RAM of DEPTH signed 32-bit words: the low stack
// (which_stack 0) fills from address 0 upward, the high stack (which_stack 1)
// from DEPTH-1 downward. Each input beat is one push or pop and gives exactly
// one result beat carrying pop_value and status (0 ok, 1 overflow on push,
// 2 empty on pop). A push is refused once the two stacks hold DEPTH words
// between them; a pop is refused on an empty stack; a refused operation leaves
// all state as it was and returns pop_value zero. One item is handled at a
// time: a push or a refused operation goes from the idle state straight to
// the result, while a successful pop first passes through a read state for the
// registered read of the single-port word RAM. The result stays on the output
// until taken, and no new input beat is accepted meanwhile. No clearing pass
// is needed after reset: a pop only ever reads a word its stack has written.
module dual_stack_shared_memory_top #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic                                in_which_stack,
  input  logic signed [dssm_pkg::DATA_W-1:0]  in_push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dssm_pkg::DATA_W-1:0]  out_pop_value,
  output logic [dssm_pkg::STATUS_W-1:0]       out_status
);

  dssm_pkg::ctrl_cmd_t cmd;
  dssm_pkg::dp_stat_t  stat;

  // sequencer: accept, optional RAM read cycle, hold result until taken
  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // counters, addressing, RAM and result register
  dssm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_op),
    .in_which_stack (in_which_stack),
    .in_push_value  (in_push_value),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status)
  );

  // status on a result beat is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == dssm_pkg::ST_OK) ||
                  (out_status == dssm_pkg::ST_OVERFLOW) ||
                  (out_status == dssm_pkg::ST_EMPTY))
    else $error("undefined status code on result");

  // a refused operation returns zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != dssm_pkg::ST_OK) |-> (out_pop_value == '0))
    else $error("non-zero value on refused operation");

  // one item in flight: no input beat right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one in flight");

  // a push answers in the next cycle and never reports empty
  a_push_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == dssm_pkg::OP_PUSH) |=>
      (out_valid && out_status != dssm_pkg::ST_EMPTY))
    else $error("push result late or wrong status");

endmodule
